[rtl/core/plist_pkg.sv]
// Shared types and codes for the positional list engine.
// Holds the request and result structs and the controller/datapath link structs.
// No dependencies.
`default_nettype none

package plist_pkg;

  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int FPOS_W  = 6;
  localparam int CNT_W   = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic        [OP_W-1:0]  op;
    logic        [POS_W-1:0] position;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic        [STAT_W-1:0] status;
    logic signed [VAL_W-1:0]  read_value;
    logic        [FPOS_W-1:0] found_position;
    logic        [CNT_W-1:0]  entry_count;
  } out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture the request
    logic init;      // first cycle: set cursor, issue first read
    logic step;      // advance cursor, issue next read
    logic shift_wr;  // write the entry just read at the cursor
    logic put_wr;    // write the request value at its position
    logic finish;    // register the result and update the count
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_place;
    logic is_erase;
    logic is_read;
    logic is_find;
    logic chk_ok;
    logic no_shift;
    logic last;
    logic hit;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/plist_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the list entry store. No dependencies.
`default_nettype none

module plist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/plist_ctrl.sv]
// Controller state machine for the positional list engine.
// Sequences checks, shift sweeps, reads and searches; depends on plist_pkg.
`default_nettype none

module plist_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire plist_pkg::dp_stat_t  stat,
  output plist_pkg::ctrl_cmd_t      cmd
);

  import plist_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SHUP   = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_SHDN   = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;
  localparam logic [2:0] S_FIND   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.init = 1'b1;
        if (!stat.chk_ok) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else if (stat.is_place) begin
          if (stat.no_shift) begin
            // appending at the end: nothing to move
            cmd.put_wr = 1'b1;
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_SHUP;
          end
        end else if (stat.is_erase) begin
          if (stat.no_shift) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_SHDN;
          end
        end else if (stat.is_read) begin
          state_nxt = S_RDWAIT;
        end else if (stat.no_shift) begin
          // search of an empty list
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_FIND;
        end
      end
      S_SHUP: begin
        cmd.step     = 1'b1;
        cmd.shift_wr = 1'b1;
        if (stat.last) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put_wr = 1'b1;
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SHDN: begin
        cmd.step     = 1'b1;
        cmd.shift_wr = 1'b1;
        if (stat.last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_RDWAIT: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_FIND: begin
        cmd.step = 1'b1;
        if (stat.hit || stat.last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A request is only taken while idle, and a result always returns to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE))
    else $error("request captured outside idle");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !busy)
    else $error("controller still busy after a result");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift_wr || cmd.put_wr) |-> busy)
    else $error("entry store written while idle");

endmodule

`default_nettype wire

[rtl/core/plist_dp.sv]
// Datapath for the positional list engine: request registers, count,
// cursor, entry store, range checks and the result register. Uses plist_pkg and plist_ram.
`default_nettype none

module plist_dp #(
  parameter int CAPACITY = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire plist_pkg::ctrl_cmd_t cmd,
  output plist_pkg::dp_stat_t       stat,
  input  wire plist_pkg::in_t       in_req,
  output logic                      out_valid,
  output plist_pkg::out_t           out_rsp
);

  import plist_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [OP_W-1:0]  op_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic [CW-1:0]    cur_r;
  logic [CW-1:0]    cur_nxt;
  logic             out_valid_r;
  out_t             out_rsp_r;

  logic [LW-1:0]    count_w;
  logic [LW-1:0]    count_nxt_w;
  logic [LW-1:0]    pos_w;
  logic [LW-1:0]    cur_w;
  logic [LW-1:0]    eff_w;
  logic [LW-1:0]    cap_w;
  logic [LW-1:0]    first_addr;
  logic [LW-1:0]    step_addr;
  logic [STAT_W-1:0] chk_code;
  logic             shift_none;
  logic             sweep_last;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  assign count_w     = LW'(count_r);
  assign count_nxt_w = LW'(count_nxt);
  assign pos_w       = LW'(pos_r);
  assign cur_w       = LW'(cur_r);
  assign cap_w       = LW'(CAPACITY);
  assign eff_w       = (op_r == OP_APPEND) ? count_w : pos_w;

  assign stat.is_place = (op_r == OP_INSERT) || (op_r == OP_APPEND);
  assign stat.is_erase = (op_r == OP_ERASE);
  assign stat.is_read  = (op_r == OP_READ);
  assign stat.is_find  = (op_r == OP_FIND);
  assign stat.hit      = (ram_rdata == val_r);
  assign stat.chk_ok   = (chk_code == ST_OK);
  assign stat.no_shift = shift_none;
  assign stat.last     = sweep_last;

  always_comb begin
    case (op_r)
      OP_INSERT, OP_APPEND: begin
        if (eff_w > count_w) begin
          chk_code = ST_BADPOS;
        end else if (count_w == cap_w) begin
          chk_code = ST_FULL;
        end else begin
          chk_code = ST_OK;
        end
      end
      OP_ERASE: begin
        if (count_w == '0) begin
          chk_code = ST_EMPTY;
        end else if (pos_w >= count_w) begin
          chk_code = ST_BADPOS;
        end else begin
          chk_code = ST_OK;
        end
      end
      OP_READ: begin
        chk_code = (pos_w >= count_w) ? ST_BADPOS : ST_OK;
      end
      OP_FIND: begin
        chk_code = ST_OK;
      end
      default: begin
        chk_code = ST_BADPOS;
      end
    endcase
  end

  // Shift sweeps read one entry ahead of the write cursor
  always_comb begin
    case (op_r)
      OP_INSERT, OP_APPEND: begin
        shift_none = (eff_w == count_w);
        sweep_last = (cur_w == eff_w + LW'(1));
        first_addr = count_w - LW'(1);
        step_addr  = cur_w - LW'(2);
        cur_nxt    = cmd.init ? count_r : (cur_r - CW'(1));
      end
      OP_ERASE: begin
        shift_none = (pos_w + LW'(1) == count_w);
        sweep_last = (cur_w + LW'(2) == count_w);
        first_addr = pos_w + LW'(1);
        step_addr  = cur_w + LW'(2);
        cur_nxt    = cmd.init ? pos_w[CW-1:0] : (cur_r + CW'(1));
      end
      OP_READ: begin
        shift_none = 1'b0;
        sweep_last = 1'b1;
        first_addr = pos_w;
        step_addr  = cur_w + LW'(1);
        cur_nxt    = cmd.init ? '0 : (cur_r + CW'(1));
      end
      default: begin
        shift_none = (count_w == '0);
        sweep_last = (cur_w + LW'(1) == count_w);
        first_addr = '0;
        step_addr  = cur_w + LW'(1);
        cur_nxt    = cmd.init ? '0 : (cur_r + CW'(1));
      end
    endcase
  end

  assign ram_raddr = cmd.init ? first_addr[AW-1:0] : step_addr[AW-1:0];
  assign ram_we    = cmd.shift_wr || cmd.put_wr;
  assign ram_waddr = cmd.shift_wr ? cur_r[AW-1:0] : eff_w[AW-1:0];
  assign ram_wdata = cmd.shift_wr ? ram_rdata : val_r;

  plist_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    count_nxt = count_r;
    if (cmd.finish && stat.chk_ok) begin
      if (stat.is_place) begin
        count_nxt = count_r + CW'(1);
      end else if (stat.is_erase) begin
        count_nxt = count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_req.op;
      pos_r <= in_req.position;
      val_r <= in_req.value;
    end
    if (cmd.init || cmd.step) begin
      cur_r <= cur_nxt;
    end
    if (cmd.finish) begin
      out_rsp_r.status         <= chk_code;
      out_rsp_r.read_value     <= (stat.is_read && stat.chk_ok) ? ram_rdata : '0;
      out_rsp_r.found_position <= (stat.is_find && cmd.step && stat.hit) ?
                                  cur_w[FPOS_W-1:0] : '0;
      out_rsp_r.entry_count    <= count_nxt_w[CNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    LW'(count_r) <= cap_w)
    else $error("entry count above capacity");

  assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.finish |=> $stable(count_r))
    else $error("entry count changed without a result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

endmodule

`default_nettype wire

[rtl/core/positional_list_engine.sv]
// Top level of the positional list engine: controller plus datapath.
// Depends on plist_pkg, plist_ctrl, plist_dp (and through it plist_ram).
`default_nettype none

// Bounded ordered list of signed 32-bit values with insert, append, erase,
// read and find. Raise start with a request while busy is low; the request
// is taken at that edge and busy stays high until the result has been
// registered. The result appears for one cycle with out_valid high and
// cannot be held off, so capture it then. Entries live in a one-write,
// one-read RAM with registered read, and that single port pair sets the
// timing: a read waits for its registered data; a rejected request, an
// append or an insert at the end ends in the check state; an insert at
// position p below the count moves the entries from p up one place, tail
// first, then writes p; an erase at p moves the entries above it down one
// place; and a find scans from position 0 to a match or the list's end.
// A new request may be given the cycle after busy falls. No clearing pass
// follows reset.

module positional_list_engine #(
  parameter int CAPACITY = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire plist_pkg::in_t  in_req,
  output logic                 out_valid,
  output plist_pkg::out_t      out_rsp
);

  import plist_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  plist_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  plist_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the positional list engine (start/busy command port).
// Predicts each result from its own copy of the list and checks every strobed result.
// Depends on plist_pkg and positional_list_engine.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import plist_pkg::*;

  localparam int CAPACITY = 64;
  localparam logic [OP_W-1:0] OP_BAD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_BAD_LAST  = 3'd7;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_req;
  logic out_valid;
  out_t out_rsp;

  positional_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  // Shadow copy of the list
  logic signed [VAL_W-1:0] list_vals [CAPACITY];
  int   list_len;
  out_t expected_rsp [$];

  int idle_pct;
  int n_sent;
  int n_checked;
  int n_fail;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("testbench NOT OK");
    $finish;
  end

  function automatic logic [STAT_W-1:0] list_place(int pos, logic signed [VAL_W-1:0] val);
    if (pos > list_len) return ST_BADPOS;
    if (list_len >= CAPACITY) return ST_FULL;
    for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
    list_vals[pos] = val;
    list_len++;
    return ST_OK;
  endfunction

  // Apply one request to the shadow list and return the result it should give
  function automatic out_t list_apply(in_t req);
    out_t rsp;
    int   pos;
    rsp = '0;
    rsp.status = ST_OK;
    pos = int'(req.position);
    case (req.op)
      OP_INSERT: rsp.status = list_place(pos, req.value);
      OP_APPEND: rsp.status = list_place(list_len, req.value);
      OP_ERASE: begin
        if (list_len == 0) begin
          rsp.status = ST_EMPTY;
        end else if (pos >= list_len) begin
          rsp.status = ST_BADPOS;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      OP_READ: begin
        if (pos < list_len) rsp.read_value = list_vals[pos];
        else rsp.status = ST_BADPOS;
      end
      OP_FIND: begin
        for (int i = 0; i < list_len; i++) begin
          if (list_vals[i] == req.value) begin
            rsp.found_position = FPOS_W'(i);
            break;
          end
        end
      end
      default: rsp.status = ST_BADPOS;
    endcase
    rsp.entry_count = CNT_W'(list_len);
    return rsp;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (expected_rsp.size() == 0) begin
        $error("result with nothing outstanding: %p", out_rsp);
        n_fail++;
      end else begin
        want = expected_rsp.pop_front();
        n_checked++;
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_rsp.status);
          n_fail++;
        end
        if (out_rsp.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_rsp.read_value);
          n_fail++;
        end
        if (out_rsp.found_position !== want.found_position) begin
          $error("found_position: expected %0d, got %0d",
                 want.found_position, out_rsp.found_position);
          n_fail++;
        end
        if (out_rsp.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_rsp.entry_count);
          n_fail++;
        end
      end
    end
  end

  task automatic sender_gap();
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
  endtask

  // Hold the request until a transfer happens, then predict its result
  task automatic send_item(logic [OP_W-1:0] op, int pos, logic signed [VAL_W-1:0] val);
    sender_gap();
    @(negedge clk);
    start  <= 1'b1;
    in_req <= '{op: op, position: POS_W'(pos), value: val};
    do @(posedge clk); while (busy);
    expected_rsp.push_back(list_apply(in_req));
    n_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) return VAL_MIN;
    if (r == 1) return VAL_MAX;
    // small pool so that duplicates turn up for find
    if (r < 5) return VAL_W'($urandom_range(0, 7));
    return $urandom;
  endfunction

  task automatic test_directed();
    idle_pct = 0;
    send_item(OP_READ, 0, 0);             // read on empty list
    send_item(OP_ERASE, 0, 0);            // erase on empty list
    send_item(OP_FIND, 0, 5);             // find on empty list
    send_item(OP_INSERT, 1, 7);           // insert past end
    send_item(OP_INSERT, 0, VAL_MIN);
    send_item(OP_APPEND, 0, VAL_MAX);
    send_item(OP_INSERT, 0, -1);          // new head
    send_item(OP_INSERT, 3, 0);           // position equal to count
    send_item(OP_INSERT, 2, 12345);       // middle
    send_item(OP_READ, 0, 0);
    send_item(OP_READ, 4, 0);
    send_item(OP_READ, 5, 0);             // read past end
    send_item(OP_READ, 127, 0);
    send_item(OP_FIND, 0, VAL_MAX);
    send_item(OP_FIND, 0, -1);
    send_item(OP_FIND, 0, 99);            // absent
    send_item(OP_ERASE, 5, 0);            // erase at count
    send_item(OP_ERASE, 127, 0);
    send_item(OP_ERASE, 0, 0);            // erase head
    send_item(OP_ERASE, 3, 0);            // erase tail
    for (int op = OP_BAD_FIRST; op <= OP_BAD_LAST; op++) send_item(OP_W'(op), 127, -1);
    send_item(OP_INSERT, 64, 1);
    send_item(OP_READ, 1, 0);
    wait_drain();
  endtask

  task automatic test_full_list();
    idle_pct = 56;
    while (list_len < CAPACITY) begin
      if ($urandom_range(1)) send_item(OP_INSERT, $urandom_range(0, list_len), $urandom);
      else send_item(OP_APPEND, 0, $urandom);
    end
    send_item(OP_APPEND, 0, 1);           // full
    send_item(OP_INSERT, CAPACITY, 1);    // full
    send_item(OP_INSERT, 0, 1);           // full
    send_item(OP_INSERT, CAPACITY + 1, 1); // position check wins
    send_item(OP_FIND, 0, list_vals[CAPACITY-1]);
    send_item(OP_READ, CAPACITY - 1, 0);
    send_item(OP_READ, CAPACITY, 0);
    send_item(OP_ERASE, CAPACITY, 0);
    send_item(OP_ERASE, CAPACITY - 1, 0);
    send_item(OP_APPEND, 0, VAL_MIN);
    // empty it from random positions
    while (list_len > 0) send_item(OP_ERASE, $urandom_range(0, list_len - 1), 0);
    send_item(OP_ERASE, 0, 0);
    wait_drain();
  endtask

  task automatic random_ops(int n_items);
    logic [OP_W-1:0] op;
    logic signed [VAL_W-1:0] val;
    int  r;
    int  pos;
    int  ins_lim;
    int  app_lim;
    int  era_lim;
    bit  grow;
    grow = 1'b1;
    repeat (n_items) begin
      if (list_len >= 56) grow = 1'b0;
      else if (list_len <= 4) grow = 1'b1;
      ins_lim = grow ? 35 : 18;
      app_lim = grow ? 50 : 26;
      era_lim = grow ? 65 : 68;
      r = $urandom_range(99);
      if (r < 4) op = OP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
      else if (r < ins_lim) op = OP_INSERT;
      else if (r < app_lim) op = OP_APPEND;
      else if (r < era_lim) op = OP_ERASE;
      else if (r < 82) op = OP_READ;
      else op = OP_FIND;
      if ($urandom_range(9) == 0) pos = $urandom_range(0, 127);
      else pos = $urandom_range(0, list_len);
      if (op == OP_FIND && list_len > 0 && $urandom_range(2) != 0)
        val = list_vals[$urandom_range(0, list_len - 1)];
      else
        val = pick_value();
      send_item(op, pos, val);
    end
    wait_drain();
  endtask

  task automatic test_random();
    idle_pct = 0;
    random_ops(100);
    idle_pct = 56;
    random_ops(100);
    idle_pct = 0;    // receiver cannot stall, so this phase runs flat out
    random_ops(100);
    idle_pct = 28;
    random_ops(100);
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    list_len  = 0;
    idle_pct  = 0;
    n_sent    = 0;
    n_checked = 0;
    n_fail    = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_list();
    test_random();

    wait_drain();
    repeat (100) @(negedge clk);
    $display("Ran %0d requests: directed corners, fill to capacity and back, random mixes",
             n_sent);
    $display("under four idling phases; %0d results checked, %0d mismatches.",
             n_checked, n_fail);
    if (n_fail == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
